// File: rtl/dq_pkg.sv
// Package with the shared types and constants of the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none
package dq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_WIDTH    = 32;
   localparam int COUNT_WIDTH   = 5;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_BUSY
   } state_type;

   typedef struct packed {
      logic                  enable;
      op_type                op;
      logic [DATA_WIDTH-1:0] value;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// File: rtl/dq_cell.sv
// One storage cell of the queue chain with its shift and fill logic.
`timescale 1ns / 1ps
`default_nettype none
module dq_cell
   import dq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cell_ctrl_type         ctrl,
   input  wire logic [DATA_WIDTH-1:0] left_data,
   input  wire logic                  left_valid,
   input  wire logic [DATA_WIDTH-1:0] right_data,
   input  wire logic                  right_valid,
   output logic [DATA_WIDTH-1:0]      data,
   output logic                       valid,
   output logic [DATA_WIDTH-1:0]      rear_tap
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  valid_ff;
   logic                  valid_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctrl.enable) begin
         unique case (ctrl.op)
            OP_PUSH_FRONT: begin
               data_in  = left_data;
               valid_in = left_valid;
            end
            OP_PUSH_REAR: begin
               if (!valid_ff && left_valid) begin
                  data_in  = ctrl.value;
                  valid_in = 1'b1;
               end
            end
            OP_POP_FRONT: begin
               data_in  = right_data;
               valid_in = right_valid;
            end
            OP_POP_REAR: begin
               if (valid_ff && !right_valid) begin
                  valid_in = 1'b0;
               end
            end
            default: begin
               data_in  = data_ff;
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign data     = data_ff;
   assign valid    = valid_ff;
   assign rear_tap = (valid_ff && !right_valid) ? data_ff : '0;

endmodule
`default_nettype wire

// File: rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue built from a chain of cells.
//
// Requests enter on the req_ channel: req_tuser carries the operation (push front,
// push rear, pop front, pop rear) and req_tdata the 32-bit value used by pushes.
// Each request transaction produces exactly one response transaction on the rsp_
// channel with the status in rsp_tuser and the element count, front and rear
// values after the request in rsp_tdata.
// The elements sit in a row of DEPTH cells, the front in the first cell. A push
// at the front or a pop from the front shifts the whole row by one cell in the
// cycle the request is taken; rear operations touch only the cell at the boundary
// of the occupied region. The rear value is gathered from the cell that sees an
// empty neighbor.
// A request is handled in two steps: the cell update in the accept cycle, then the
// response register load in the busy state, once that register is free. No new
// request is taken before that load. While a response waits, the next request
// is still accepted and updates the cells; it then waits until the response
// register is free. Reset empties the queue at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_queue
   import dq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // push_value[31:0]
   input  wire logic [1:0]  req_tuser,   // req_type[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // element_count[4:0], front_value[36:5],
                                         // rear_value[68:37], zero[71:69]
   output logic [1:0]       rsp_tuser    // status[1:0]
);

   localparam int CountBits = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0]  cell_data [DEPTH];
   logic [DATA_WIDTH-1:0]  cell_tap  [DEPTH];
   logic [DEPTH-1:0]       cell_valid;
   cell_ctrl_type          ctrl;

   state_type              state_ff;
   state_type              state_in;
   status_type             status_ff;
   status_type             status_in;
   logic [CountBits-1:0]   count_ff;
   logic [CountBits-1:0]   count_in;
   logic                   rsp_tvalid_ff;
   logic                   rsp_tvalid_in;
   logic [71:0]            rsp_tdata_ff;
   logic [71:0]            rsp_tdata_in;
   logic [1:0]             rsp_tuser_ff;
   logic [1:0]             rsp_tuser_in;

   logic                   accept;
   logic                   load;
   logic [DATA_WIDTH-1:0]  front_value;
   logic [DATA_WIDTH-1:0]  rear_value;
   logic [CountBits+4:0]   count_wide;
   op_type                 req_op;

   assign req_op = op_type'(req_tuser);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         dq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .left_data   (ctrl.value),
            .left_valid  (1'b1),
            .right_data  (cell_data[i+1]),
            .right_valid (cell_valid[i+1]),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .rear_tap    (cell_tap[i])
         );
      end else if (i == DEPTH - 1) begin : g_last
         dq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .left_data   (cell_data[i-1]),
            .left_valid  (cell_valid[i-1]),
            .right_data  ('0),
            .right_valid (1'b0),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .rear_tap    (cell_tap[i])
         );
      end else begin : g_mid
         dq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .left_data   (cell_data[i-1]),
            .left_valid  (cell_valid[i-1]),
            .right_data  (cell_data[i+1]),
            .right_valid (cell_valid[i+1]),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .rear_tap    (cell_tap[i])
         );
      end
   end

   always_comb begin
      rear_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rear_value = rear_value | cell_tap[i];
      end
   end

   assign front_value = cell_valid[0] ? cell_data[0] : '0;
   assign count_wide  = {5'd0, count_ff};

   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      count_in      = count_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      req_tready    = 1'b0;
      accept        = 1'b0;
      load          = 1'b0;
      ctrl.enable   = 1'b0;
      ctrl.op       = req_op;
      ctrl.value    = req_tdata;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            if (accept) begin
               unique case (req_op)
                  OP_PUSH_FRONT, OP_PUSH_REAR: begin
                     status_in = cell_valid[DEPTH-1] ? ST_FULL : ST_DONE;
                  end
                  OP_POP_FRONT, OP_POP_REAR: begin
                     status_in = cell_valid[0] ? ST_DONE : ST_EMPTY;
                  end
                  default: begin
                     status_in = ST_DONE;
                  end
               endcase
               if (status_in == ST_DONE) begin
                  ctrl.enable = 1'b1;
                  if (req_op == OP_PUSH_FRONT || req_op == OP_PUSH_REAR) begin
                     count_in = count_ff + CountBits'(1);
                  end else begin
                     count_in = count_ff - CountBits'(1);
                  end
               end
               state_in = S_BUSY;
            end
         end
         S_BUSY: begin
            load = !rsp_tvalid_ff || rsp_tready;
            if (load) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = status_ff;
               rsp_tdata_in  = {3'd0, rear_value, front_value, count_wide[4:0]};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_count_matches_cells: assert property (
      @(posedge clock) disable iff (reset)
      $countones(cell_valid) == 32'(count_ff))
      else $error("Element count differs from the number of occupied cells.");

   a_cells_contiguous: assert property (
      @(posedge clock) disable iff (reset)
      (cell_valid & (cell_valid + 1'b1)) == '0)
      else $error("Occupied cells do not form a run starting at the front.");

   a_count_bounded: assert property (
      @(posedge clock) disable iff (reset)
      32'(count_ff) <= DEPTH)
      else $error("Element count exceeds the queue depth.");

   a_empty_refusal: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == S_BUSY && status_ff == ST_EMPTY) |-> count_ff == '0)
      else $error("A pop was refused while the queue held elements.");

   a_accept_then_busy: assert property (
      @(posedge clock) disable iff (reset)
      accept |=> state_ff == S_BUSY)
      else $error("An accepted transaction did not move the control to busy.");

endmodule
`default_nettype wire
